/* sv/c8_pkg.sv */
// c8_pkg: shared types, opcode constants, font table and small helper functions
// for the chip-8 instruction core
// no dependencies
package c8_pkg;

    localparam logic [11:0] PC_RESET   = 12'h200;
    localparam logic [11:0] FONT_BYTES = 12'd80;
    localparam logic [11:0] MEM_LAST   = 12'hFFF;
    localparam logic [11:0] VREG_COUNT = 12'd16;

    // item kinds
    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_EXEC = 2'd1;
    localparam logic [1:0] K_READ = 2'd2;

    // result status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE   = 4'h3;
    localparam logic [3:0] OPG_SNE  = 4'h4;
    localparam logic [3:0] OPG_SEV  = 4'h5;
    localparam logic [3:0] OPG_LD   = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNEV = 4'h9;
    localparam logic [3:0] OPG_LDI  = 4'hA;
    localparam logic [3:0] OPG_JPV  = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [7:0] EX_SKP  = 8'h9E;
    localparam logic [7:0] EX_SKNP = 8'hA1;

    localparam logic [7:0] FX_LDVDT = 8'h07;
    localparam logic [7:0] FX_KEY   = 8'h0A;
    localparam logic [7:0] FX_SDT   = 8'h15;
    localparam logic [7:0] FX_SST   = 8'h18;
    localparam logic [7:0] FX_ADDI  = 8'h1E;
    localparam logic [7:0] FX_FONT  = 8'h29;
    localparam logic [7:0] FX_BCD   = 8'h33;
    localparam logic [7:0] FX_STORE = 8'h55;
    localparam logic [7:0] FX_LOAD  = 8'h65;

    // 8xyn functions
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       wr_flag;
        logic       bad;
    } alu_out_t;

    localparam logic [7:0] FONT_ROM [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // rotate right of a 64-bit row
    function automatic logic [63:0] rotr64(input logic [63:0] w, input logic [5:0] sh);
        logic [127:0] d;
        d = {w, w} >> sh;
        return d[63:0];
    endfunction

    // decimal digit sel of v: 0 hundreds, 1 tens, else ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        if (v >= 8'd200) begin
            h   = 2'd2;
            rem = v - 8'd200;
        end else if (v >= 8'd100) begin
            h   = 2'd1;
            rem = v - 8'd100;
        end else begin
            h   = 2'd0;
            rem = v;
        end
        prod = 15'(rem) * 15'd205;
        t    = 4'(prod >> 11);
        o    = rem - 8'(8'(t) * 8'd10);
        if (sel == 2'd0) begin
            return {6'b0, h};
        end else if (sel == 2'd1) begin
            return {4'b0, t};
        end else begin
            return o;
        end
    endfunction

    function automatic logic [3:0] lowest_key(input logic [15:0] k);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (k[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* sv/c8_ram.sv */
// c8_ram: generic single-write, single-read ram with registered read data
// no dependencies
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/c8_alu.sv */
// c8_alu: register-to-register arithmetic and logic of the 8xyn group
// depends on c8_pkg
module c8_alu import c8_pkg::*; (
    input  logic [3:0] fn,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output alu_out_t   res
);

    logic [8:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        res = '0;
        unique case (fn)
            ALU_MOV: res.res = b;
            ALU_OR:  res.res = a | b;
            ALU_AND: res.res = a & b;
            ALU_XOR: res.res = a ^ b;
            ALU_ADD:
            begin
                res.res     = sum[7:0];
                res.flag    = sum[8];
                res.wr_flag = 1'b1;
            end
            ALU_SUB:
            begin
                res.res     = a - b;
                res.flag    = (a >= b);
                res.wr_flag = 1'b1;
            end
            ALU_SHR:
            begin
                res.res     = {1'b0, a[7:1]};
                res.flag    = a[0];
                res.wr_flag = 1'b1;
            end
            ALU_SUBN:
            begin
                res.res     = b - a;
                res.flag    = (b >= a);
                res.wr_flag = 1'b1;
            end
            ALU_SHL:
            begin
                res.res     = {a[6:0], 1'b0};
                res.flag    = a[7];
                res.wr_flag = 1'b1;
            end
            default: res.bad = 1'b1;
        endcase
    end

endmodule

/* sv/chip8_instruction_core.sv */
// chip8_instruction_core: chip-8 core with memory, display and register file in rams
// depends on c8_pkg, c8_ram, c8_alu
// a load goes to done, a row read via the row state; an instruction runs fetch,
// register reads, execute, any vf write, tick, done; dxyn, fx55/fx65, fx33 loop per item
// one word at a time; each fetch, read and write step of an instruction is one access of the ram ports
// reset: a pass over every memory address writes the font and zeros into memory and clears v0-vf
module chip8_instruction_core import c8_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] address,
    input  logic [7:0]  data_byte,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    input  logic [4:0]  row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] pc,
    output logic [15:0] opcode,
    output logic [63:0] row_pixels,
    output logic        drew,
    output logic        sound_on,
    output logic [1:0]  status
);

    // one-hot sequencer
    typedef enum logic [17:0] {
        S_INIT  = 18'd1,
        S_IDLE  = 18'd2,
        S_ROW   = 18'd4,
        S_F0    = 18'd8,
        S_F1    = 18'd16,
        S_F2    = 18'd32,
        S_RY    = 18'd64,
        S_EXEC  = 18'd128,
        S_DR0   = 18'd256,
        S_DR1   = 18'd512,
        S_ST0   = 18'd1024,
        S_ST1   = 18'd2048,
        S_LD0   = 18'd4096,
        S_LD1   = 18'd8192,
        S_BCD   = 18'd16384,
        S_WFLAG = 18'd32768,
        S_TICK  = 18'd65536,
        S_DONE  = 18'd131072
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] init_cnt_reg, init_cnt_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [3:0]  sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic [31:0] scr_valid_reg, scr_valid_next;
    logic        out_valid_reg, out_valid_next;

    // latched word and working payload
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [4:0]  row_reg, row_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [3:0]  k_reg, k_next;
    logic        flag_reg, flag_next;
    logic [1:0]  stat_reg, stat_next;
    logic        drew_reg, drew_next;
    logic [63:0] pix_reg, pix_next;

    // output register
    logic [11:0] out_pc_reg, out_pc_next;
    logic [15:0] out_op_reg, out_op_next;
    logic [63:0] out_pix_reg, out_pix_next;
    logic        out_drew_reg, out_drew_next;
    logic        out_snd_reg, out_snd_next;
    logic [1:0]  out_stat_reg, out_stat_next;

    // return stack, read only at the stack pointer
    logic [11:0] stk_reg [16];
    logic        stk_we;
    logic [3:0]  stk_waddr;
    logic [11:0] stk_wdata;

    // ram ports
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        vr_we;
    logic [3:0]  vr_waddr, vr_raddr;
    logic [7:0]  vr_wdata, vr_rdata;
    logic        scr_we;
    logic [4:0]  scr_waddr, scr_raddr;
    logic [63:0] scr_wdata, scr_rdata;

    // instruction fields
    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [11:0] pc_inc, pc_skip;
    logic [11:0] mem_addr_k;
    logic [4:0]  draw_row;
    logic [63:0] sprite, old_row;
    alu_out_t    alu_res;

    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_kk  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];

    assign pc_inc     = pc_reg + 12'd2;
    assign pc_skip    = pc_reg + 12'd4;
    // i + k wraps in the 4 kb space
    assign mem_addr_k = idx_reg[11:0] + {8'b0, k_reg};
    // sprite rows wrap vertically, columns rotate horizontally
    assign draw_row   = vy_reg[4:0] + {1'b0, k_reg};
    assign sprite     = rotr64({mem_rdata, 56'b0}, vx_reg[5:0]);
    // a row never drawn since reset or cls reads as blank
    assign old_row    = scr_valid_reg[draw_row] ? scr_rdata : 64'b0;

    c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .raddr (vr_raddr),
        .rdata (vr_rdata)
    );

    c8_ram #(.WIDTH(64), .DEPTH(32)) u_screen (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    // vx from the register, vy straight off the register-file read port
    c8_alu u_alu (
        .fn  (op_n),
        .a   (vx_reg),
        .b   (vr_rdata),
        .res (alu_res)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign pc         = out_pc_reg;
    assign opcode     = out_op_reg;
    assign row_pixels = out_pix_reg;
    assign drew       = out_drew_reg;
    assign sound_on   = out_snd_reg;
    assign status     = out_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        st_next        = st_reg;
        scr_valid_next = scr_valid_reg;
        out_valid_next = out_valid_reg && out_stall;

        kind_next = kind_reg;
        keys_next = keys_reg;
        rnd_next  = rnd_reg;
        row_next  = row_reg;
        op_next   = op_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        k_next    = k_reg;
        flag_next = flag_reg;
        stat_next = stat_reg;
        drew_next = drew_reg;
        pix_next  = pix_reg;

        out_pc_next   = out_pc_reg;
        out_op_next   = out_op_reg;
        out_pix_next  = out_pix_reg;
        out_drew_next = out_drew_reg;
        out_snd_next  = out_snd_reg;
        out_stat_next = out_stat_reg;

        mem_we    = 1'b0;
        mem_waddr = mem_addr_k;
        mem_wdata = 8'b0;
        mem_raddr = pc_reg;
        vr_we     = 1'b0;
        vr_waddr  = op_x;
        vr_wdata  = 8'b0;
        vr_raddr  = op_x;
        scr_we    = 1'b0;
        scr_waddr = draw_row;
        scr_wdata = old_row ^ sprite;
        scr_raddr = draw_row;
        stk_we    = 1'b0;
        stk_waddr = sp_reg + 4'd1;
        stk_wdata = pc_inc;

        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass: font, then zeros; v registers cleared alongside
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = (init_cnt_reg < FONT_BYTES) ? FONT_ROM[init_cnt_reg[6:0]] : 8'b0;
                if (init_cnt_reg < VREG_COUNT)
                begin
                    vr_we    = 1'b1;
                    vr_waddr = init_cnt_reg[3:0];
                end
                init_cnt_next = init_cnt_reg + 12'd1;
                if (init_cnt_reg == MEM_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    keys_next = keys;
                    rnd_next  = random_byte;
                    row_next  = row;
                    stat_next = ST_OK;
                    drew_next = 1'b0;
                    pix_next  = 64'b0;
                    priority if (kind == K_LOAD)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = address;
                        mem_wdata  = data_byte;
                        state_next = S_DONE;
                    end
                    else if (kind == K_EXEC)
                    begin
                        state_next = S_F0;
                    end
                    else if (kind == K_READ)
                    begin
                        scr_raddr  = row;
                        state_next = S_ROW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW:
            begin
                pix_next   = scr_valid_reg[row_reg] ? scr_rdata : 64'b0;
                state_next = S_DONE;
            end
            S_F0:
            begin
                mem_raddr  = pc_reg;
                state_next = S_F1;
            end
            S_F1:
            begin
                mem_raddr      = pc_reg + 12'd1;
                op_next[15:8]  = mem_rdata;
                state_next     = S_F2;
            end
            S_F2:
            begin
                op_next[7:0] = mem_rdata;
                vr_raddr     = op_reg[11:8];
                state_next   = S_RY;
            end
            S_RY:
            begin
                vx_next    = vr_rdata;
                // bnnn needs v0 instead of vy
                vr_raddr   = (op_reg[15:12] == OPG_JPV) ? 4'h0 : op_y;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                vy_next    = vr_rdata;
                pc_next    = pc_inc;
                state_next = S_TICK;
                unique case (op_reg[15:12])
                    OPG_SYS:
                    begin
                        if (op_reg == OP_CLS)
                        begin
                            scr_valid_next = 32'b0;
                            drew_next      = 1'b1;
                        end
                        else if (op_reg == OP_RET)
                        begin
                            pc_next = stk_reg[sp_reg];
                            sp_next = sp_reg - 4'd1;
                        end
                        else
                        begin
                            stat_next = ST_BAD;
                        end
                    end
                    OPG_JP:
                    begin
                        pc_next = op_nnn;
                    end
                    OPG_CALL:
                    begin
                        sp_next = sp_reg + 4'd1;
                        stk_we  = 1'b1;
                        pc_next = op_nnn;
                    end
                    OPG_SE:
                    begin
                        if (vx_reg == op_kk)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    OPG_SNE:
                    begin
                        if (vx_reg != op_kk)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    OPG_SEV:
                    begin
                        if (vx_reg == vr_rdata)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    OPG_LD:
                    begin
                        vr_we    = 1'b1;
                        vr_wdata = op_kk;
                    end
                    OPG_ADD:
                    begin
                        vr_we    = 1'b1;
                        vr_wdata = vx_reg + op_kk;
                    end
                    OPG_ALU:
                    begin
                        if (alu_res.bad)
                        begin
                            stat_next = ST_BAD;
                        end
                        else
                        begin
                            vr_we    = 1'b1;
                            vr_wdata = alu_res.res;
                            if (alu_res.wr_flag)
                            begin
                                // vf lands after vx
                                flag_next  = alu_res.flag;
                                state_next = S_WFLAG;
                            end
                        end
                    end
                    OPG_SNEV:
                    begin
                        if (vx_reg != vr_rdata)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    OPG_LDI:
                    begin
                        idx_next = {4'b0, op_nnn};
                    end
                    OPG_JPV:
                    begin
                        pc_next = op_nnn + {4'b0, vr_rdata};
                    end
                    OPG_RND:
                    begin
                        vr_we    = 1'b1;
                        vr_wdata = rnd_reg & op_kk;
                    end
                    OPG_DRW:
                    begin
                        drew_next = 1'b1;
                        flag_next = 1'b0;
                        k_next    = 4'd0;
                        // empty sprite still clears vf
                        state_next = (op_n == 4'd0) ? S_WFLAG : S_DR0;
                    end
                    OPG_KEY:
                    begin
                        if (op_kk == EX_SKP)
                        begin
                            if (keys_reg[vx_reg[3:0]])
                            begin
                                pc_next = pc_skip;
                            end
                        end
                        else if (op_kk == EX_SKNP)
                        begin
                            if (!keys_reg[vx_reg[3:0]])
                            begin
                                pc_next = pc_skip;
                            end
                        end
                        else
                        begin
                            stat_next = ST_BAD;
                        end
                    end
                    OPG_MISC:
                    begin
                        unique case (op_kk)
                            FX_LDVDT:
                            begin
                                vr_we    = 1'b1;
                                vr_wdata = dt_reg;
                            end
                            FX_KEY:
                            begin
                                if (keys_reg == 16'b0)
                                begin
                                    // hold on this instruction until a key is down
                                    pc_next   = pc_reg;
                                    stat_next = ST_WAIT;
                                end
                                else
                                begin
                                    vr_we    = 1'b1;
                                    vr_wdata = {4'b0, lowest_key(keys_reg)};
                                end
                            end
                            FX_SDT:
                            begin
                                dt_next = vx_reg;
                            end
                            FX_SST:
                            begin
                                st_next = vx_reg;
                            end
                            FX_ADDI:
                            begin
                                idx_next = idx_reg + {8'b0, vx_reg};
                            end
                            FX_FONT:
                            begin
                                idx_next = {10'b0, vx_reg[3:0], 2'b00} + {12'b0, vx_reg[3:0]};
                            end
                            FX_BCD:
                            begin
                                k_next     = 4'd0;
                                state_next = S_BCD;
                            end
                            FX_STORE:
                            begin
                                k_next     = 4'd0;
                                state_next = S_ST0;
                            end
                            FX_LOAD:
                            begin
                                k_next     = 4'd0;
                                state_next = S_LD0;
                            end
                            default:
                            begin
                                stat_next = ST_BAD;
                            end
                        endcase
                    end
                    default:
                    begin
                        stat_next = ST_BAD;
                    end
                endcase
            end
            S_DR0:
            begin
                mem_raddr  = mem_addr_k;
                scr_raddr  = draw_row;
                state_next = S_DR1;
            end
            S_DR1:
            begin
                // read-modify-write of one display row
                scr_we                   = 1'b1;
                scr_valid_next[draw_row] = 1'b1;
                if ((old_row & sprite) != 64'b0)
                begin
                    flag_next = 1'b1;
                end
                if (k_reg == op_n - 4'd1)
                begin
                    state_next = S_WFLAG;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_DR0;
                end
            end
            S_ST0:
            begin
                vr_raddr   = k_reg;
                state_next = S_ST1;
            end
            S_ST1:
            begin
                mem_we    = 1'b1;
                mem_wdata = vr_rdata;
                if (k_reg == op_x)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_ST0;
                end
            end
            S_LD0:
            begin
                mem_raddr  = mem_addr_k;
                state_next = S_LD1;
            end
            S_LD1:
            begin
                vr_we    = 1'b1;
                vr_waddr = k_reg;
                vr_wdata = mem_rdata;
                if (k_reg == op_x)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_LD0;
                end
            end
            S_BCD:
            begin
                mem_we    = 1'b1;
                mem_wdata = bcd_digit(vx_reg, k_reg[1:0]);
                if (k_reg == 4'd2)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
            S_WFLAG:
            begin
                vr_we      = 1'b1;
                vr_waddr   = 4'hF;
                vr_wdata   = {7'b0, flag_reg};
                state_next = S_TICK;
            end
            S_TICK:
            begin
                // timers count down once per executed instruction
                if (dt_reg != 8'd0)
                begin
                    dt_next = dt_reg - 8'd1;
                end
                if (st_reg != 8'd0)
                begin
                    st_next = st_reg - 8'd1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_pc_next    = pc_reg;
                    out_op_next    = (kind_reg == K_EXEC) ? op_reg : 16'b0;
                    out_pix_next   = pix_reg;
                    out_drew_next  = drew_reg;
                    out_snd_next   = (st_reg != 8'd0);
                    out_stat_next  = stat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= 12'b0;
            pc_reg        <= PC_RESET;
            idx_reg       <= 16'b0;
            sp_reg        <= 4'b0;
            dt_reg        <= 8'b0;
            st_reg        <= 8'b0;
            scr_valid_reg <= 32'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            sp_reg        <= sp_next;
            dt_reg        <= dt_next;
            st_reg        <= st_next;
            scr_valid_reg <= scr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        keys_reg     <= keys_next;
        rnd_reg      <= rnd_next;
        row_reg      <= row_next;
        op_reg       <= op_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        k_reg        <= k_next;
        flag_reg     <= flag_next;
        stat_reg     <= stat_next;
        drew_reg     <= drew_next;
        pix_reg      <= pix_next;
        out_pc_reg   <= out_pc_next;
        out_op_reg   <= out_op_next;
        out_pix_reg  <= out_pix_next;
        out_drew_reg <= out_drew_next;
        out_snd_reg  <= out_snd_next;
        out_stat_reg <= out_stat_next;
        if (stk_we)
        begin
            stk_reg[stk_waddr] <= stk_wdata;
        end
    end

    // pc only moves when an instruction executes
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(pc_reg))
        else $error("pc changed outside execute");

    // cls blanks every row at once
    a_cls_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == OP_CLS) |=> (scr_valid_reg == 32'b0))
        else $error("screen not blank after cls");

    // sprite row counter stays inside the sprite height
    a_draw_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DR1) |-> (k_reg < op_reg[3:0]))
        else $error("sprite row counter overran");

endmodule

/* dv/chip8_instruction_core_test.sv */
// chip8_instruction_core_test: self-checking bench for the chip-8 instruction core
// depends on c8_pkg and chip8_instruction_core; a clocked driver and monitor around
// an in-bench chip-8 interpreter that predicts every result word
`timescale 1ns / 1ps

module chip8_instruction_core_test;
    import c8_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [4:0]  row;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] pc;
    logic [15:0] opcode;
    logic [63:0] row_pixels;
    logic        drew;
    logic        sound_on;
    logic [1:0]  status;

    chip8_instruction_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .address(address), .data_byte(data_byte), .keys(keys),
        .random_byte(random_byte), .row(row),
        .out_valid(out_valid), .out_stall(out_stall),
        .pc(pc), .opcode(opcode), .row_pixels(row_pixels), .drew(drew),
        .sound_on(sound_on), .status(status)
    );

    // one input word as the driver sends it
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] keys;
        logic [7:0]  random_byte;
        logic [4:0]  row;
    } c8_word_t;

    // one result word as the core returns it
    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [63:0] row_pixels;
        logic        drew;
        logic        sound_on;
        logic [1:0]  status;
    } c8_result_t;

    c8_word_t   pending_words[$];
    c8_result_t expected_results[$];

    // shadow machine state
    logic [7:0]  sh_mem [0:4095];
    logic [63:0] sh_screen [0:31];
    logic [7:0]  sh_v [0:15];
    logic [15:0] sh_i;
    logic [11:0] sh_pc;
    logic [11:0] sh_stack [0:15];
    logic [3:0]  sh_sp;
    logic [7:0]  sh_dt;
    logic [7:0]  sh_st;
    // stack depth the stimulus knows is filled, so a return never pops a blank slot
    int          calls_live;

    int  errors;
    int  idle_pct;
    int  stall_pct;
    bit  stim_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic reset_shadow();
        for (int a = 0; a < 4096; a++)
        begin
            sh_mem[a] = (a < 80) ? FONT_ROM[a] : 8'h00;
        end
        for (int r = 0; r < 32; r++)
        begin
            sh_screen[r] = '0;
        end
        for (int r = 0; r < 16; r++)
        begin
            sh_v[r] = '0;
            sh_stack[r] = '0;
        end
        sh_i = '0;
        sh_pc = 12'h200;
        sh_sp = '0;
        sh_dt = '0;
        sh_st = '0;
    endtask

    // interpreter step: applies one word to the shadow state and returns its result
    function automatic c8_result_t predict_chip8(input c8_word_t w);
        c8_result_t  res;
        logic [15:0] op;
        logic [11:0] nxt;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy, flag, spr;
        logic [11:0] nnn;
        logic [5:0]  xs;
        logic [4:0]  ys;
        logic [63:0] m;
        logic        hit;
        int          k;
        res = '0;
        if (w.kind == K_LOAD)
        begin
            sh_mem[w.address] = w.data_byte;
        end
        else if (w.kind == K_READ)
        begin
            res.row_pixels = sh_screen[w.row];
        end
        else if (w.kind == K_EXEC)
        begin
            op  = {sh_mem[sh_pc], sh_mem[12'(sh_pc + 12'd1)]};
            nxt = sh_pc + 12'd2;
            x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
            vx = sh_v[x]; vy = sh_v[y];
            res.opcode = op;
            case (op[15:12])
                OPG_SYS:
                begin
                    if (op == OP_CLS)
                    begin
                        for (int r = 0; r < 32; r++) sh_screen[r] = '0;
                        res.drew = 1'b1;
                    end
                    else if (op == OP_RET)
                    begin
                        nxt = sh_stack[sh_sp];
                        sh_sp = sh_sp - 4'd1;
                    end
                    else res.status = ST_BAD;
                end
                OPG_JP:   nxt = nnn;
                OPG_CALL:
                begin
                    sh_sp = sh_sp + 4'd1;
                    sh_stack[sh_sp] = nxt;
                    nxt = nnn;
                end
                OPG_SE:   if (vx == kk) nxt = nxt + 12'd2;
                OPG_SNE:  if (vx != kk) nxt = nxt + 12'd2;
                OPG_SEV:  if (vx == vy) nxt = nxt + 12'd2;
                OPG_LD:   sh_v[x] = kk;
                OPG_ADD:  sh_v[x] = vx + kk;
                OPG_ALU:
                begin
                    case (n)
                        ALU_MOV: sh_v[x] = vy;
                        ALU_OR:  sh_v[x] = vx | vy;
                        ALU_AND: sh_v[x] = vx & vy;
                        ALU_XOR: sh_v[x] = vx ^ vy;
                        ALU_ADD:
                        begin
                            flag = ({1'b0, vx} + {1'b0, vy}) > 9'h0FF;
                            sh_v[x] = vx + vy; sh_v[15] = flag;
                        end
                        ALU_SUB:
                        begin
                            flag = vx >= vy; sh_v[x] = vx - vy; sh_v[15] = flag;
                        end
                        ALU_SHR:
                        begin
                            flag = vx[0]; sh_v[x] = vx >> 1; sh_v[15] = flag;
                        end
                        ALU_SUBN:
                        begin
                            flag = vy >= vx; sh_v[x] = vy - vx; sh_v[15] = flag;
                        end
                        ALU_SHL:
                        begin
                            flag = vx[7]; sh_v[x] = vx << 1; sh_v[15] = flag;
                        end
                        default: res.status = ST_BAD;
                    endcase
                end
                OPG_SNEV: if (vx != vy) nxt = nxt + 12'd2;
                OPG_LDI:  sh_i = {4'h0, nnn};
                OPG_JPV:  nxt = nnn + {4'h0, sh_v[0]};
                OPG_RND:  sh_v[x] = w.random_byte & kk;
                OPG_DRW:
                begin
                    // coordinates were read before vf is cleared
                    sh_v[15] = 8'h00;
                    xs = vx[5:0]; ys = vy[4:0]; hit = 1'b0;
                    for (int r = 0; r < n; r++)
                    begin
                        spr = sh_mem[12'(sh_i + 16'(r))];
                        m = {spr, 56'h0};
                        m = (m >> xs) | ((xs == 0) ? 64'h0 : (m << (7'd64 - xs)));
                        if ((sh_screen[5'(ys + r)] & m) != 0) hit = 1'b1;
                        sh_screen[5'(ys + r)] ^= m;
                    end
                    sh_v[15] = {7'h0, hit};
                    res.drew = 1'b1;
                end
                OPG_KEY:
                begin
                    if (kk == EX_SKP)
                    begin
                        if (w.keys[vx[3:0]]) nxt = nxt + 12'd2;
                    end
                    else if (kk == EX_SKNP)
                    begin
                        if (!w.keys[vx[3:0]]) nxt = nxt + 12'd2;
                    end
                    else res.status = ST_BAD;
                end
                default:
                begin
                    case (kk)
                        FX_LDVDT: sh_v[x] = sh_dt;
                        FX_KEY:
                        begin
                            if (w.keys == 0)
                            begin
                                nxt = sh_pc;
                                res.status = ST_WAIT;
                            end
                            else
                            begin
                                k = 0;
                                while (!w.keys[k]) k++;
                                sh_v[x] = 8'(k);
                            end
                        end
                        FX_SDT:  sh_dt = vx;
                        FX_SST:  sh_st = vx;
                        FX_ADDI: sh_i = sh_i + {8'h0, vx};
                        FX_FONT: sh_i = 16'd5 * {12'h0, vx[3:0]};
                        FX_BCD:
                        begin
                            sh_mem[sh_i[11:0]] = vx / 100;
                            sh_mem[12'(sh_i + 16'd1)] = (vx / 10) % 10;
                            sh_mem[12'(sh_i + 16'd2)] = vx % 10;
                        end
                        FX_STORE:
                            for (int r = 0; r <= x; r++) sh_mem[12'(sh_i + 16'(r))] = sh_v[r];
                        FX_LOAD:
                            for (int r = 0; r <= x; r++) sh_v[r] = sh_mem[12'(sh_i + 16'(r))];
                        default: res.status = ST_BAD;
                    endcase
                end
            endcase
            sh_pc = nxt;
            if (sh_dt != 0) sh_dt--;
            if (sh_st != 0) sh_st--;
        end
        res.pc = sh_pc;
        res.sound_on = (sh_st != 0);
        return res;
    endfunction

    // driver: feeds pending words, valid held steady while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {kind, address, data_byte, keys, random_byte, row} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                c8_word_t w;
                w = pending_words.pop_front();
                expected_results.push_back(predict_chip8(w));
                {kind, address, data_byte, keys, random_byte, row} <= w;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: compare each accepted result with the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected, pc %h", pc);
                errors++;
            end
            else
            begin
                c8_result_t e;
                e = expected_results.pop_front();
                if (pc !== e.pc)
                begin
                    $error("pc expected %h actual %h", e.pc, pc); errors++;
                end
                if (opcode !== e.opcode)
                begin
                    $error("opcode expected %h actual %h", e.opcode, opcode); errors++;
                end
                if (row_pixels !== e.row_pixels)
                begin
                    $error("row_pixels expected %h actual %h", e.row_pixels, row_pixels);
                    errors++;
                end
                if (drew !== e.drew)
                begin
                    $error("drew expected %b actual %b", e.drew, drew); errors++;
                end
                if (sound_on !== e.sound_on)
                begin
                    $error("sound_on expected %b actual %b", e.sound_on, sound_on);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %h actual %h", e.status, status); errors++;
                end
            end
        end
    end

    // stimulus helpers: program bytes go in as load words at the queue tail
    logic [11:0] load_pc;

    task automatic push_word(input logic [1:0] k, input logic [11:0] a, input logic [7:0] d,
                             input logic [15:0] kb, input logic [7:0] rb, input logic [4:0] r);
        c8_word_t w;
        w = '{kind: k, address: a, data_byte: d, keys: kb, random_byte: rb, row: r};
        pending_words.push_back(w);
    endtask

    // place op at load_pc and run it; the program counter is kept on load_pc
    task automatic run_op(input logic [15:0] op, input logic [15:0] kb);
        push_word(K_LOAD, load_pc, op[15:8], 16'($urandom), 8'($urandom), 5'($urandom));
        push_word(K_LOAD, load_pc + 12'd1, op[7:0], 16'($urandom), 8'($urandom),
                  5'($urandom));
        push_word(K_EXEC, 12'($urandom), 8'($urandom), kb, 8'($urandom), 5'($urandom));
    endtask

    // pick an instruction; returns are only made when a call is live
    function automatic logic [15:0] random_op();
        logic [15:0] r;
        int sel;
        r = 16'($urandom);
        sel = $urandom_range(19);
        case (sel)
            0: r = OP_CLS;
            1: r = (calls_live > 0) ? OP_RET : {OPG_LD, r[11:0]};
            2: r = {OPG_ALU, r[11:4], 4'($urandom_range(7))};
            3: r = {OPG_ALU, r[11:4], ALU_SHL};
            4: r = {OPG_DRW, r[11:4], 4'($urandom_range(4))};
            5: r = {OPG_MISC, r[11:8], FX_KEY};
            6: r = {OPG_KEY, r[11:8], ($urandom_range(1) ? EX_SKP : EX_SKNP)};
            7:
            begin
                case ($urandom_range(8))
                    0: r[7:0] = FX_LDVDT; 1: r[7:0] = FX_SDT; 2: r[7:0] = FX_SST;
                    3: r[7:0] = FX_ADDI;  4: r[7:0] = FX_FONT; 5: r[7:0] = FX_BCD;
                    6: r[7:0] = FX_STORE; 7: r[7:0] = FX_LOAD; default: ;
                endcase
                r[15:12] = OPG_MISC;
            end
            8: r = {OPG_LDI, r[11:0]};
            9: r = {OPG_CALL, r[11:0]};
            default: if (r[15:12] == OPG_SYS && r != OP_CLS && calls_live == 0)
                         r = {OPG_SYS, r[11:0] == 12'h0EE ? 12'h0EF : r[11:0]};
        endcase
        if (r == OP_RET && calls_live == 0) r = 16'h00EF;
        return r;
    endfunction

    task automatic random_item();
        logic [15:0] op;
        logic [15:0] kb;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            push_word(K_READ, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                      5'($urandom));
        end
        else if (pick == 1)
        begin
            // loads into the data area, addresses 0x300 to 0xeff
            push_word(K_LOAD, 12'($urandom_range(12'hEFF, 12'h300)), 8'($urandom),
                      16'($urandom), 8'($urandom), 5'($urandom));
        end
        else
        begin
            op = random_op();
            kb = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
            if (op[15:12] == OPG_CALL) calls_live++;
            if (op == OP_RET) calls_live--;
            run_op(op, kb);
        end
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        stim_done = 1'b0;
        calls_live = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {kind, address, data_byte, keys, random_byte, row} = '0;
        reset_shadow();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the program counter lands wherever an op sends it; each op is loaded at the
        // shadow pc, which we track by waiting until the queue of words has drained
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                3: begin idle_pct = 10; stall_pct = 10; end
                default: begin idle_pct = $urandom_range(40); stall_pct = 30; end
            endcase
            for (int it = 0; it < ((phase == 0) ? 40 : 78); it++)
            begin
                // sync with the shadow so load_pc is the real next pc
                wait (pending_words.size() == 0);
                load_pc = sh_pc;
                if (phase == 0 && it < 24)
                begin
                    case (it)
                        0:  run_op(16'h6FFF, 16'h0);
                        1:  run_op(16'h60FF, 16'h0);
                        2:  run_op(16'h80F4, 16'h0);
                        3:  run_op(16'h8015, 16'h0);
                        4:  run_op(16'h80F7, 16'h0);
                        5:  run_op(16'h80F6, 16'h0);
                        6:  run_op(16'h8F0E, 16'h0);
                        7:  run_op(16'hF029, 16'h0);
                        8:  run_op(16'hD3F5, 16'h0);
                        9:  run_op(16'hD3F5, 16'h0);
                        10: run_op(16'hD000, 16'h0);
                        11: run_op(16'h613E, 16'h0);
                        12: run_op(16'hD115, 16'h0);
                        13: run_op(16'hF10A, 16'h0);
                        14: run_op(16'hF10A, 16'h8000);
                        15: run_op(16'hF115, 16'h0);
                        16: run_op(16'hF118, 16'h0);
                        17: run_op(16'hA3FF, 16'h0);
                        18: run_op(16'hF133, 16'h0);
                        19: run_op(16'hFF55, 16'h0);
                        20: run_op(16'h5FFF, 16'h0);
                        21: run_op(16'h00E0, 16'h0);
                        22: run_op(16'hE1A1, 16'hFFFF);
                        default: run_op(16'hFFFF, 16'h0);
                    endcase
                    push_word(K_READ, 12'h0, 8'h0, 16'h0, 8'h0, 5'd31);
                end
                else
                begin
                    random_item();
                end
            end
            // hold off until every result has returned
            wait (pending_words.size() == 0 && expected_results.size() == 0);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
